// ===== rtl/round_robin_task_table_macros.svh =====
// Assertion macros for the round-robin task table checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ROUND_ROBIN_TASK_TABLE_MACROS_SVH
`define ROUND_ROBIN_TASK_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrtt_pkg.sv =====
// Shared types and constants for the round-robin task table.
// Used by the address unit, the slot table and the top level.
`timescale 1ns / 1ps

package rrtt_pkg;

  typedef logic [1:0] add_op_t;

  localparam add_op_t ADD_OP_SUM = 2'd0;
  localparam add_op_t ADD_OP_PC  = 2'd1;
  localparam add_op_t ADD_OP_PSR = 2'd2;
  localparam add_op_t ADD_OP_TOP = 2'd3;

  localparam logic [31:0] PC_OFS_NEG  = 32'hFFFF_FFF8;
  localparam logic [31:0] PSR_OFS_NEG = 32'hFFFF_FFFC;

  typedef struct packed {
    logic claim;
    logic select;
  } tbl_ctl_t;

endpackage

// ===== rtl/round_robin_task_table.sv =====
// Channel | Direction | Beat contents
// in_     | input     | mode, stack_base, stack_words, task_entry
// out_    | output    | kind, status, slot, saved_sp, pc_word_addr, psr_word_addr, idle
//
// A create beat takes 4 adder steps (sum, PC, PSR, top) and then scans the free-slot
// table one slot per cycle; a select beat steps the current pointer, then loads its result.
// The address adder is shared, so the adder steps of a create beat run one after another.
// Synchronous active-low reset empties the table and parks the current pointer on the
// sentinel. A new beat is taken while a result waits; a stalled result delays the next finish.
`timescale 1ns / 1ps

module round_robin_task_table #(
  parameter int NUM_TASKS   = 8,
  parameter int FRAME_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_stack_base,
  input  logic [15:0] in_stack_words,
  input  logic [31:0] in_task_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_status,
  output logic [2:0]  out_slot,
  output logic [31:0] out_saved_sp,
  output logic [31:0] out_pc_word_addr,
  output logic [31:0] out_psr_word_addr,
  output logic        out_idle
);
  import rrtt_pkg::*;

  localparam int LINK_W = $clog2(NUM_TASKS + 1);
  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_PC     = 3'd2;
  localparam logic [2:0] S_PSR    = 3'd3;
  localparam logic [2:0] S_TOP    = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_SEL    = 3'd6;
  localparam logic [2:0] S_SELOUT = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       base_r;
  logic [15:0]       words_r;
  logic [31:0]       pc_r;
  logic [31:0]       psr_r;
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic              out_valid_r;
  logic              out_kind_r;
  logic              out_status_r;
  logic [2:0]        out_slot_r;
  logic [31:0]       out_top_r;
  logic [31:0]       out_pc_r;
  logic [31:0]       out_psr_r;
  logic              out_idle_r;

  logic              add_en;
  add_op_t           add_op;
  logic [31:0]       add_res;
  tbl_ctl_t          tbl_ctl;
  logic              slot_free;
  logic [LINK_W-1:0] sel_idx;
  logic [31:0]       sel_top;
  logic              sel_idle;
  logic              out_free;
  logic              load_create;
  logic              load_select;

  rrtt_addr_unit #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_addr (
    .clk         (clk),
    .en          (add_en),
    .op          (add_op),
    .stack_base  (base_r),
    .stack_words (words_r),
    .result      (add_res)
  );

  rrtt_table #(
    .NUM_TASKS(NUM_TASKS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tbl_ctl),
    .scan_idx  (scan_r),
    .new_top   (add_res),
    .slot_free (slot_free),
    .sel_idx   (sel_idx),
    .sel_top   (sel_top),
    .sel_idle  (sel_idle)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    add_en         = 1'b0;
    add_op         = ADD_OP_SUM;
    tbl_ctl.claim  = 1'b0;
    tbl_ctl.select = 1'b0;
    load_create    = 1'b0;
    load_select    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_mode ? S_SEL : S_SUM;
        end
      end
      S_SUM: begin
        add_en    = 1'b1;
        add_op    = ADD_OP_SUM;
        state_nxt = S_PC;
      end
      S_PC: begin
        add_en    = 1'b1;
        add_op    = ADD_OP_PC;
        state_nxt = S_PSR;
      end
      S_PSR: begin
        add_en    = 1'b1;
        add_op    = ADD_OP_PSR;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        add_en    = 1'b1;
        add_op    = ADD_OP_TOP;
        scan_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (slot_free || (scan_r == LAST_SLOT)) begin
          if (out_free) begin
            load_create   = 1'b1;
            tbl_ctl.claim = slot_free;
            state_nxt     = S_IDLE;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_SEL: begin
        tbl_ctl.select = 1'b1;
        state_nxt      = S_SELOUT;
      end
      S_SELOUT: begin
        if (out_free) begin
          load_select = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_create || load_select) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (state_r == S_IDLE && in_valid) begin
      base_r  <= in_stack_base;
      words_r <= in_stack_words;
    end
    if (state_r == S_PSR) begin
      pc_r <= add_res;
    end
    if (state_r == S_TOP) begin
      psr_r <= add_res;
    end
    if (load_create) begin
      out_kind_r   <= 1'b0;
      out_status_r <= !slot_free;
      out_slot_r   <= slot_free ? 3'(scan_r) : 3'd0;
      out_top_r    <= slot_free ? add_res : 32'd0;
      out_pc_r     <= pc_r;
      out_psr_r    <= psr_r;
      out_idle_r   <= 1'b0;
    end
    if (load_select) begin
      out_kind_r   <= 1'b1;
      out_status_r <= 1'b0;
      out_slot_r   <= sel_idle ? 3'd0 : 3'(sel_idx);
      out_top_r    <= sel_top;
      out_pc_r     <= 32'd0;
      out_psr_r    <= 32'd0;
      out_idle_r   <= sel_idle;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_saved_sp      = out_top_r;
  assign out_pc_word_addr  = out_pc_r;
  assign out_psr_word_addr = out_psr_r;
  assign out_idle          = out_idle_r;

endmodule

// ===== rtl/rrtt_addr_unit.sv =====
// Shared 32-bit adder that forms the stack addresses one per step.
// Depends on rrtt_pkg for the operation codes.
`timescale 1ns / 1ps

module rrtt_addr_unit #(
  parameter int FRAME_WORDS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  rrtt_pkg::add_op_t op,
  input  logic [31:0]      stack_base,
  input  logic [15:0]      stack_words,
  output logic [31:0]      result
);
  import rrtt_pkg::*;

  localparam logic [31:0] TOP_OFS_NEG = ~(32'(FRAME_WORDS) << 2) + 32'd1;

  logic [31:0] end_r;
  logic [31:0] res_r;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] sum;

  always_comb begin
    opa = (op == ADD_OP_SUM) ? stack_base : end_r;
    case (op)
      ADD_OP_SUM: opb = {14'd0, stack_words, 2'b00};
      ADD_OP_PC:  opb = PC_OFS_NEG;
      ADD_OP_PSR: opb = PSR_OFS_NEG;
      ADD_OP_TOP: opb = TOP_OFS_NEG;
      default:    opb = 32'd0;
    endcase
    sum = opa + opb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= sum;
      if (op == ADD_OP_SUM) begin
        end_r <= sum;
      end
    end
  end

  assign result = res_r;

endmodule

// ===== rtl/rrtt_table.sv =====
// Task slot table: used bits, saved stack tops, links and the current pointer.
// Depends on rrtt_pkg for the control struct.
`timescale 1ns / 1ps

module rrtt_table #(
  parameter int NUM_TASKS = 8,
  localparam int LINK_W = $clog2(NUM_TASKS + 1),
  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrtt_pkg::tbl_ctl_t ctl,
  input  logic [SLOT_W-1:0]  scan_idx,
  input  logic [31:0]        new_top,
  output logic               slot_free,
  output logic [LINK_W-1:0]  sel_idx,
  output logic [31:0]        sel_top,
  output logic               sel_idle
);
  import rrtt_pkg::*;

  localparam logic [LINK_W-1:0] SENT = LINK_W'(NUM_TASKS);

  logic              used_r [NUM_TASKS];
  logic [31:0]       top_r  [NUM_TASKS];
  logic [LINK_W-1:0] link_r [NUM_TASKS];
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] cur_r;
  logic [LINK_W-1:0] sel_r;
  logic [LINK_W-1:0] head_c;
  logic [LINK_W-1:0] step1;
  logic [LINK_W-1:0] step_nxt;

  function automatic logic [LINK_W-1:0] clamp(input logic [LINK_W-1:0] v);
    clamp = (v > SENT) ? SENT : v;
  endfunction

  always_comb begin
    head_c = clamp(head_r);
    if (cur_r >= SENT) begin
      step1 = head_c;
    end else begin
      step1 = clamp(link_r[cur_r[SLOT_W-1:0]]);
    end
    step_nxt = (step1 == SENT) ? head_c : step1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        used_r[i] <= 1'b0;
      end
      head_r <= SENT;
      cur_r  <= SENT;
      sel_r  <= SENT;
    end else begin
      if (ctl.claim) begin
        used_r[scan_idx] <= 1'b1;
        head_r           <= LINK_W'(scan_idx);
      end
      if (ctl.select) begin
        cur_r <= step_nxt;
        sel_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.claim) begin
      top_r[scan_idx]  <= new_top;
      link_r[scan_idx] <= head_c;
    end
  end

  assign slot_free = !used_r[scan_idx];
  assign sel_idx   = sel_r;
  assign sel_idle  = (sel_r >= SENT);
  assign sel_top   = sel_idle ? 32'd0 : top_r[sel_r[SLOT_W-1:0]];

endmodule

// ===== rtl/rrtt_checker.sv =====
// Port-level checker for the round-robin task table, bound to the top level.
// Depends on round_robin_task_table_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "round_robin_task_table_macros.svh"

module rrtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic        out_status,
  input logic [2:0]  out_slot,
  input logic [31:0] out_saved_sp,
  input logic [31:0] out_pc_word_addr,
  input logic [31:0] out_psr_word_addr,
  input logic        out_idle
);

  `RRTT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not make the block busy")
  `RRTT_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_saved_sp), "stalled result beat changed")
  `RRTT_ASSERT_NOW(a_psr_follows_pc, out_valid && !out_kind, out_psr_word_addr == out_pc_word_addr + 32'd4, "status word address is not next to the entry word")
  `RRTT_ASSERT_NOW(a_idle_empty, out_valid && out_kind && out_idle, out_slot == 3'd0 && out_saved_sp == 32'd0 && !out_status, "idle select answer carries a slot")
  `RRTT_ASSERT_NOW(a_create_not_idle, out_valid && !out_kind, !out_idle, "create answer reports idle")

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (.*);

// ===== sim/round_robin_task_table_tb.sv =====
// Self-checking testbench for round_robin_task_table: a directed table, then random beats.
// The expected results come from a predictor of the slot table and the ring of task links.
// It depends only on the RTL of the block.
`timescale 1ns / 1ps

module round_robin_task_table_tb;

  localparam int          NUM_TASKS   = 8;
  localparam int          FRAME_WORDS = 16;
  localparam logic [31:0] FRAME_W32   = FRAME_WORDS;
  localparam logic [3:0]  SENTINEL    = 4'(NUM_TASKS);

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_SELECT = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_COIN   = 2'd1;
  localparam logic [1:0] STALL_HEAVY  = 2'd2;
  localparam logic [1:0] STALL_PERIOD = 2'd3;

  localparam int RAND_ITEMS  = 2000;
  localparam int SETTLE      = 40;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic        mode;
    logic [31:0] base;
    logic [15:0] words;
    logic [31:0] entry;
  } task_beat_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [2:0]  slot;
    logic [31:0] saved_sp;
    logic [31:0] pc_addr;
    logic [31:0] psr_addr;
    logic        idle;
  } task_result_t;

  typedef struct packed {
    task_beat_t   beat;
    logic         typed;
    task_result_t want;
  } stim_row_t;

  localparam task_result_t NO_RESULT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_stack_base;
  logic [15:0] in_stack_words;
  logic [31:0] in_task_entry;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic        out_status;
  logic [2:0]  out_slot;
  logic [31:0] out_saved_sp;
  logic [31:0] out_pc_word_addr;
  logic [31:0] out_psr_word_addr;
  logic        out_idle;

  logic        slot_used [0:NUM_TASKS-1];
  logic [31:0] saved_top [0:NUM_TASKS-1];
  logic [3:0]  ring_link [0:NUM_TASKS];
  logic [3:0]  cur_entry;

  task_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int           errors = 0;
  int           quiet_cycles;
  logic [7:0]   stall_tick;
  logic [1:0]   stall_mode;
  task_result_t got;
  task_result_t want;

  round_robin_task_table #(
    .NUM_TASKS(NUM_TASKS),
    .FRAME_WORDS(FRAME_WORDS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_stack_base(in_stack_base),
    .in_stack_words(in_stack_words),
    .in_task_entry(in_task_entry),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_saved_sp(out_saved_sp),
    .out_pc_word_addr(out_pc_word_addr),
    .out_psr_word_addr(out_psr_word_addr),
    .out_idle(out_idle)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] follow_link(input logic [3:0] idx);
    logic [3:0] n;
    if (idx > SENTINEL) begin
      idx = SENTINEL;
    end
    n = ring_link[idx];
    if (n > SENTINEL) begin
      n = SENTINEL;
    end
    return n;
  endfunction

  function automatic task_result_t schedule_step(input task_beat_t b);
    task_result_t r;
    logic [31:0]  w32;
    logic [31:0]  top;
    logic [3:0]   c;
    bit           found;
    int           i;
    r = '0;
    r.kind = b.mode;
    w32 = {16'd0, b.words};
    if (b.mode == MODE_CREATE) begin
      r.pc_addr = b.base + ((w32 - 32'd2) << 2);
      r.psr_addr = b.base + ((w32 - 32'd1) << 2);
      found = 1'b0;
      for (i = 0; i < NUM_TASKS; i++) begin
        if (!found && !slot_used[i]) begin
          top = b.base + ((w32 - FRAME_W32) << 2);
          slot_used[i] = 1'b1;
          saved_top[i] = top;
          ring_link[i] = follow_link(SENTINEL);
          ring_link[SENTINEL] = i[3:0];
          r.slot = i[2:0];
          r.saved_sp = top;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = STATUS_FULL;
      end
    end else begin
      c = follow_link(cur_entry);
      if (c == SENTINEL) begin
        c = follow_link(c);
      end
      cur_entry = c;
      if (c >= SENTINEL) begin
        r.idle = 1'b1;
      end else begin
        r.slot = c[2:0];
        r.saved_sp = saved_top[c];
      end
    end
    return r;
  endfunction

  function automatic task_result_t make_result(input logic kind, input logic status,
                                               input logic [2:0] slot, input logic [31:0] top,
                                               input logic [31:0] pc, input logic [31:0] psr,
                                               input logic idle);
    task_result_t r;
    r.kind = kind;
    r.status = status;
    r.slot = slot;
    r.saved_sp = top;
    r.pc_addr = pc;
    r.psr_addr = psr;
    r.idle = idle;
    return r;
  endfunction

  function automatic void add_row(input logic mode, input logic [31:0] base,
                                  input logic [15:0] words, input logic [31:0] entry,
                                  input logic typed, input task_result_t want_r);
    stim_row_t row;
    row.beat.mode = mode;
    row.beat.base = base;
    row.beat.words = words;
    row.beat.entry = entry;
    row.typed = typed;
    row.want = want_r;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic send_beat(input task_beat_t b, input logic typed, input task_result_t want_r);
    task_result_t pred;
    in_valid <= 1'b1;
    in_mode <= b.mode;
    in_stack_base <= b.base;
    in_stack_words <= b.words;
    in_task_entry <= b.entry;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = schedule_step(b);
    pending_results.push_back(typed ? want_r : pred);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_mode <= 1'($urandom_range(0, 1));
      in_stack_base <= $urandom;
      in_stack_words <= 16'($urandom);
      in_task_entry <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic task_beat_t random_beat();
    task_beat_t b;
    b.mode = ($urandom_range(0, 9) < 3) ? MODE_CREATE : MODE_SELECT;
    b.base = $urandom;
    b.entry = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        b.words = 16'h0000;
      end
      1: begin
        b.words = 16'hFFFF;
      end
      2: begin
        b.words = 16'($urandom_range(0, FRAME_WORDS + 1));
      end
      default: begin
        b.words = 16'($urandom);
      end
    endcase
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick <= '0;
      stall_mode <= STALL_NONE;
    end else begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == 8'd0) begin
        stall_mode <= 2'($urandom_range(0, 3));
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_COIN: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 7) != 0);
        end
        default: begin
          out_stall <= (stall_tick[4:0] < 5'd12);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        got = make_result(out_kind, out_status, out_slot, out_saved_sp, out_pc_word_addr,
                          out_psr_word_addr, out_idle);
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("slot", 32'(want.slot), 32'(got.slot));
        check_field("saved_sp", want.saved_sp, got.saved_sp);
        check_field("pc_word_addr", want.pc_addr, got.pc_addr);
        check_field("psr_word_addr", want.psr_addr, got.psr_addr);
        check_field("idle", 32'(want.idle), 32'(got.idle));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int sent;
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_CREATE;
    in_stack_base = '0;
    in_stack_words = '0;
    in_task_entry = '0;
    for (k = 0; k < NUM_TASKS; k++) begin
      slot_used[k] = 1'b0;
      saved_top[k] = '0;
      ring_link[k] = '0;
    end
    ring_link[SENTINEL] = SENTINEL;
    cur_entry = SENTINEL;

    // Walk an empty ring, fill every slot with edge-case sizes while selecting in between,
    // then hit the full table.
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b1,
            make_result(MODE_SELECT, STATUS_OK, 3'd0, 32'h0, 32'h0, 32'h0, 1'b1));
    add_row(MODE_CREATE, 32'h0, 16'd16, 32'h0, 1'b1,
            make_result(MODE_CREATE, STATUS_OK, 3'd0, 32'h0, 32'h38, 32'h3C, 1'b0));
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_SELECT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'hFFFF_FFFC, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT);
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'h2000_0000, 16'd0, 32'h0800_0101, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'h2000_0100, 16'd1, 32'h0800_0201, 1'b0, NO_RESULT);
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'hFFFF_FFFF, 16'd15, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 1'b0, NO_RESULT);
    add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'h0000_1000, 16'd17, 32'h0800_0301, 1'b0, NO_RESULT);
    add_row(MODE_CREATE, 32'h0000_1000, 16'h0020, 32'h0800_0401, 1'b1,
            make_result(MODE_CREATE, STATUS_FULL, 3'd0, 32'h0, 32'h1078, 32'h107C, 1'b0));
    add_row(MODE_CREATE, 32'h0, 16'h0, 32'h0, 1'b1,
            make_result(MODE_CREATE, STATUS_FULL, 3'd0, 32'h0, 32'hFFFF_FFF8, 32'hFFFF_FFFC,
                        1'b0));
    for (k = 0; k < 5; k++) begin
      add_row(MODE_SELECT, 32'h0, 16'h0, 32'h0, 1'b0, NO_RESULT);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < directed_rows.size(); k++) begin
      send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);
      idle_for($urandom_range(0, 2));
    end
    drain_results();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        send_beat(random_beat(), 1'b0, NO_RESULT);
        sent++;
        if (sent == RAND_ITEMS / 2) begin
          drain_results();
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
